// ===== hdl/two_channel_windowed_peak_counter_assert.svh =====
// assertion macros for the windowed peak counter
`ifndef TWO_CHANNEL_WINDOWED_PEAK_COUNTER_ASSERT_SVH
`define TWO_CHANNEL_WINDOWED_PEAK_COUNTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TWPC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("twpc assertion failed");

// next-cycle implication, disabled during reset
`define TWPC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("twpc assertion failed");

`endif

// ===== hdl/twpc_pkg.sv =====
// constants and register indexes shared by the windowed peak counter
`default_nettype none

package twpc_pkg;

    localparam int TICK_W      = 24;
    localparam int LEVEL_W     = 13;
    localparam int BLOCK_W     = 8;
    localparam int OUT_COUNT_W = 16;
    localparam int RAW_W       = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 72;

    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_TICKS      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PEAK_THRESHOLD   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCKS_PER_CYCLE = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LED_MIN_PEAKS    = 2'd3;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    localparam logic [TICK_W-1:0]      BLOCK_TICKS_RESET    = 24'd500000;
    localparam logic [LEVEL_W-1:0]     PEAK_THRESHOLD_RESET = 13'd500;
    localparam logic [BLOCK_W-1:0]     BLOCKS_PER_CYCLE_RESET = 8'd20;
    localparam logic [OUT_COUNT_W-1:0] LED_MIN_PEAKS_RESET  = 16'd5;

    localparam logic [BLOCK_W-1:0] LED_ON_BLOCK  = 8'd1;
    localparam logic [BLOCK_W-1:0] LED_OFF_BLOCK = 8'd2;

endpackage

`default_nettype wire

// ===== hdl/two_channel_windowed_peak_counter.sv =====
// two-channel windowed peak counter with tick timer, led and stimulus control
// result: a sample item shows its result in the cycle after it is accepted
// throughput: one item per cycle while the output is not stalled; a tick item updates the timer and gives no result
// a single registered pass from the input handshake to the result register sets this
// reset: synchronous active-low aresetn clears counters, timer, block index and led,
// raises the stimulus and loads the default configuration
`default_nettype none

`include "two_channel_windowed_peak_counter_assert.svh"

module two_channel_windowed_peak_counter
    import twpc_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // raw_word_a [15:0], raw_word_b [31:16]
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    // req_type [0]
    input  wire logic                  s_tuser,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // sample_a [12:0], sample_b [25:13], block_closed [26], closed_block_index [34:27],
    // closed_count_a [50:35], closed_count_b [66:51], cycle_restarted [67],
    // led_level [68], stim_level [69], zero [71:70]
    output logic [M_DATA_W-1:0]        m_tdata
);

    localparam int WideBits = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;
    localparam logic [WideBits-1:0] OutMax = WideBits'({OUT_COUNT_W{1'b1}});

    // configuration
    logic [TICK_W-1:0]      block_ticks_reg;
    logic [LEVEL_W-1:0]     peak_threshold_reg;
    logic [BLOCK_W-1:0]     blocks_per_cycle_reg;
    logic [OUT_COUNT_W-1:0] led_min_peaks_reg;

    // state
    logic [TICK_W-1:0]     elapsed_reg, elapsed_next;
    logic [BLOCK_W-1:0]    block_idx_reg, block_idx_next;
    logic                  armed_a_reg, armed_a_next;
    logic                  armed_b_reg, armed_b_next;
    logic [COUNT_BITS-1:0] count_a_reg, count_a_next;
    logic [COUNT_BITS-1:0] count_b_reg, count_b_next;
    logic [COUNT_BITS-1:0] first_a_reg, first_a_next;
    logic [COUNT_BITS-1:0] first_b_reg, first_b_next;
    logic                  led_reg, led_next;
    logic                  stim_reg, stim_next;

    // result register
    logic                   m_valid_reg;
    logic [LEVEL_W-1:0]     sample_a_reg, sample_b_reg;
    logic                   closed_reg, closed_next;
    logic [BLOCK_W-1:0]     closed_idx_reg, closed_idx_next;
    logic [OUT_COUNT_W-1:0] closed_a_reg, closed_a_next;
    logic [OUT_COUNT_W-1:0] closed_b_reg, closed_b_next;
    logic                   wrapped_reg, wrapped_next;

    logic                s_accept;
    logic                sample_accept;
    logic [LEVEL_W-1:0]  sample_a;
    logic [LEVEL_W-1:0]  sample_b;
    logic [WideBits-1:0] wide_a;
    logic [WideBits-1:0] wide_b;

    assign s_tready      = !m_valid_reg || m_tready;
    assign s_accept      = s_tvalid && s_tready;
    assign sample_accept = s_accept && (s_tuser == REQ_SAMPLE);
    assign sample_a      = s_tdata[RAW_W-1:3];
    assign sample_b      = s_tdata[S_DATA_W-1:RAW_W+3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_ticks_reg      <= BLOCK_TICKS_RESET;
            peak_threshold_reg   <= PEAK_THRESHOLD_RESET;
            blocks_per_cycle_reg <= BLOCKS_PER_CYCLE_RESET;
            led_min_peaks_reg    <= LED_MIN_PEAKS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_BLOCK_TICKS:      block_ticks_reg      <= cfg_wdata[TICK_W-1:0];
                REG_PEAK_THRESHOLD:   peak_threshold_reg   <= cfg_wdata[LEVEL_W-1:0];
                REG_BLOCKS_PER_CYCLE: blocks_per_cycle_reg <= cfg_wdata[BLOCK_W-1:0];
                REG_LED_MIN_PEAKS:    led_min_peaks_reg    <= cfg_wdata[OUT_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        elapsed_next    = elapsed_reg;
        block_idx_next  = block_idx_reg;
        armed_a_next    = armed_a_reg;
        armed_b_next    = armed_b_reg;
        count_a_next    = count_a_reg;
        count_b_next    = count_b_reg;
        first_a_next    = first_a_reg;
        first_b_next    = first_b_reg;
        led_next        = led_reg;
        stim_next       = stim_reg;
        closed_next     = 1'b0;
        closed_idx_next = '0;
        closed_a_next   = '0;
        closed_b_next   = '0;
        wrapped_next    = 1'b0;
        wide_a          = WideBits'(count_a_reg);
        wide_b          = WideBits'(count_b_reg);

        if (s_accept && (s_tuser == REQ_TICK)) begin
            if (elapsed_reg != '1) begin
                elapsed_next = elapsed_reg + 1'b1;
            end
        end else if (sample_accept) begin
            if (block_idx_reg == LED_OFF_BLOCK) begin
                led_next = 1'b0;
            end

            // cycle wrap
            if (block_idx_reg == blocks_per_cycle_reg) begin
                count_a_next   = '0;
                count_b_next   = '0;
                block_idx_next = '0;
                stim_next      = 1'b1;
                wrapped_next   = 1'b1;
            end

            // block close
            wide_a = WideBits'(count_a_next);
            wide_b = WideBits'(count_b_next);
            if (elapsed_reg > block_ticks_reg) begin
                closed_next     = 1'b1;
                closed_idx_next = block_idx_next;
                closed_a_next   = (wide_a > OutMax) ? '1 : wide_a[OUT_COUNT_W-1:0];
                closed_b_next   = (wide_b > OutMax) ? '1 : wide_b[OUT_COUNT_W-1:0];
                if (block_idx_next == '0) begin
                    first_a_next = count_a_next;
                    first_b_next = count_b_next;
                end
                stim_next    = 1'b0;
                count_a_next = '0;
                count_b_next = '0;
                elapsed_next = '0;
                if (block_idx_next != '1) begin
                    block_idx_next = block_idx_next + 1'b1;
                end
            end

            // peak detection, channel a
            if (sample_a > peak_threshold_reg && !armed_a_reg) begin
                armed_a_next = 1'b1;
            end else if (sample_a < peak_threshold_reg && armed_a_reg) begin
                if (count_a_next != '1) begin
                    count_a_next = count_a_next + 1'b1;
                end
                armed_a_next = 1'b0;
            end

            // peak detection, channel b
            if (sample_b > peak_threshold_reg && !armed_b_reg) begin
                armed_b_next = 1'b1;
            end else if (sample_b < peak_threshold_reg && armed_b_reg) begin
                if (count_b_next != '1) begin
                    count_b_next = count_b_next + 1'b1;
                end
                armed_b_next = 1'b0;
            end

            if (block_idx_next == LED_ON_BLOCK &&
                (WideBits'(first_a_next) > WideBits'(led_min_peaks_reg) ||
                 WideBits'(first_b_next) > WideBits'(led_min_peaks_reg))) begin
                led_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg   <= '0;
            block_idx_reg <= '0;
            armed_a_reg   <= 1'b0;
            armed_b_reg   <= 1'b0;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            led_reg       <= 1'b0;
            stim_reg      <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            elapsed_reg   <= elapsed_next;
            block_idx_reg <= block_idx_next;
            armed_a_reg   <= armed_a_next;
            armed_b_reg   <= armed_b_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            led_reg       <= led_next;
            stim_reg      <= stim_next;
            if (sample_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // first-block counts and result payload
    always_ff @(posedge aclk) begin
        first_a_reg <= first_a_next;
        first_b_reg <= first_b_next;
        if (sample_accept) begin
            sample_a_reg   <= sample_a;
            sample_b_reg   <= sample_b;
            closed_reg     <= closed_next;
            closed_idx_reg <= closed_idx_next;
            closed_a_reg   <= closed_a_next;
            closed_b_reg   <= closed_b_next;
            wrapped_reg    <= wrapped_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, stim_reg, led_reg, wrapped_reg, closed_b_reg, closed_a_reg,
                       closed_idx_reg, closed_reg, sample_b_reg, sample_a_reg};

    `TWPC_ASSERT_NEXT(a_sample_gives_item, aclk, aresetn, sample_accept, m_valid_reg)
    `TWPC_ASSERT_NEXT(a_tick_gives_no_item, aclk, aresetn,
        s_accept && (s_tuser == REQ_TICK) && (!m_valid_reg || m_tready), !m_valid_reg)
    `TWPC_ASSERT_SAME(a_open_block_fields_zero, aclk, aresetn, m_valid_reg && !closed_reg,
        closed_idx_reg == '0 && closed_a_reg == '0 && closed_b_reg == '0)
    `TWPC_ASSERT_SAME(a_wrap_raises_stim, aclk, aresetn,
        m_valid_reg && wrapped_reg && !closed_reg, stim_reg)
    `TWPC_ASSERT_NEXT(a_close_clears_timer, aclk, aresetn,
        sample_accept && (elapsed_reg > block_ticks_reg), elapsed_reg == '0)

endmodule

`default_nettype wire
